### src/rrts_pkg.sv
// Shared types, constants and codes for the round-robin task table scheduler.
package rrts_pkg;
  localparam int TASK_SLOTS = 512;
  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int CNT_MAX = 1023;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0, ST_RUNNABLE = 2'd1, ST_RUNNING = 2'd2, ST_BLOCKED = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    FN_SUBMIT = 3'd0, FN_ACQUIRE = 3'd1, FN_YIELD = 3'd2,
    FN_EXIT = 3'd3, FN_BLOCK = 3'd4, FN_UNBLOCK = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    STS_DONE = 2'd0, STS_NONE = 2'd1, STS_BAD = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_READ, S_WAIT, S_ACC, S_UPD, S_OUT
  } fsm_t;

  // slot record: stamp, running, runnable, blocked totals
  localparam int REC_W = 256;

  // search request/response between sequencer and searcher
  typedef struct packed {
    logic       start;
    logic [1:0] want;      // state searched for
    logic       rotate;    // start at pointer instead of zero
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } srch_rsp_t;
endpackage

### src/round_robin_task_table_scheduler.sv
// Top level of the round-robin task table scheduler.
// One operation per input beat and one result beat per operation. Submit and
// acquire first scan the slot state RAM one slot per cycle. Every operation
// then takes a registered read of the slot state and record RAMs, the 64-bit
// accounting adds and, when the slot changes state, the write back before its
// result is offered. The block takes no new beat until its result is taken.
// Slots are claimed lowest first, so a fill mark counts the slots ever
// claimed; slots at or above it read as free with zero times, and no clearing
// pass is needed after reset.
module round_robin_task_table_scheduler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func[2:0], task_index[11:3], timestamp[75:12], zero pad
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], granted_slot[10:2], running_count[20:11],
  // runnable_count[30:21], blocked_count[40:31], finished_total[72:41],
  // total_running_time[136:73], total_runnable_time[200:137],
  // total_blocked_time[264:201], slot_running_time[328:265],
  // slot_runnable_time[392:329], slot_blocked_time[456:393], zero pad
  output logic [463:0] m_tdata
);
  localparam int W = rrts_pkg::SLOT_W;

  rrts_pkg::fsm_t state, state_next;
  logic [2:0]   func;
  logic [8:0]   idx;
  logic [63:0]  t;
  logic [W-1:0] slot, ptr;
  logic [W:0]   fill;
  logic [1:0]   status;
  logic [1:0]   old_st, new_st;
  logic         have_slot, do_change, clr_rec;
  logic [9:0]   cnt [3];
  logic [31:0]  fin;
  logic [63:0]  gt [3];
  logic [255:0] rec, rec_wr, rd;
  logic         ram_we;

  rrts_pkg::srch_req_t sreq;
  rrts_pkg::srch_rsp_t srsp;
  logic [1:0]          rd_st;
  logic                st_wr;

  rrts_search u_search (
    .clk, .rst, .req(sreq), .ptr, .fill, .wr(st_wr), .wr_slot(slot),
    .wr_st(new_st), .rd_slot(slot), .rd_st, .rsp(srsp)
  );

  rrts_ram #(.WIDTH(rrts_pkg::REC_W), .DEPTH(rrts_pkg::TASK_SLOTS)) u_rec (
    .clk, .we(ram_we), .addr(slot), .wdata(rec_wr), .rdata(rd)
  );

  // state kind index: 0 running, 1 runnable, 2 blocked
  function automatic logic [1:0] kind(input logic [1:0] s);
    case (s)
      rrts_pkg::ST_RUNNING:  kind = 2'd0;
      rrts_pkg::ST_RUNNABLE: kind = 2'd1;
      default:               kind = 2'd2;
    endcase
  endfunction

  logic [1:0]  ok, nk;
  logic        acc_en;
  logic [63:0] slot_tot, slot_sum, glob_sum;
  assign ok = kind(old_st);
  assign nk = kind(new_st);
  assign acc_en = (rec[63:0] != 64'd0) && (old_st != rrts_pkg::ST_FREE);
  always_comb begin
    case (ok)
      2'd0:    slot_tot = rec[127:64];
      2'd1:    slot_tot = rec[191:128];
      default: slot_tot = rec[255:192];
    endcase
  end

  rrts_acct u_acct (
    .clk, .stamp(rec[63:0]), .t, .slot_tot, .glob_tot(gt[ok]),
    .slot_sum, .glob_sum
  );

  always_comb begin
    rec_wr = rec;
    rec_wr[63:0] = t;
    if (acc_en) begin
      case (ok)
        2'd0:    rec_wr[127:64]  = slot_sum;
        2'd1:    rec_wr[191:128] = slot_sum;
        default: rec_wr[255:192] = slot_sum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rrts_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    sreq = '0;
    s_tready = 1'b0;
    ram_we = 1'b0;
    st_wr = 1'b0;
    case (state)
      rrts_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tdata[2:0] == rrts_pkg::FN_SUBMIT ||
              s_tdata[2:0] == rrts_pkg::FN_ACQUIRE) begin
            sreq.start = 1'b1;
            sreq.want = (s_tdata[2:0] == rrts_pkg::FN_SUBMIT) ?
                        rrts_pkg::ST_FREE : rrts_pkg::ST_RUNNABLE;
            sreq.rotate = (s_tdata[2:0] == rrts_pkg::FN_ACQUIRE);
            state_next = rrts_pkg::S_SEARCH;
          end else state_next = rrts_pkg::S_READ;
        end
      end
      rrts_pkg::S_SEARCH: if (srsp.done) state_next = rrts_pkg::S_READ;
      rrts_pkg::S_READ:   state_next = rrts_pkg::S_WAIT;
      rrts_pkg::S_WAIT:   state_next = rrts_pkg::S_ACC;
      rrts_pkg::S_ACC:    state_next = do_change ? rrts_pkg::S_UPD : rrts_pkg::S_OUT;
      rrts_pkg::S_UPD: begin
        ram_we = 1'b1;
        st_wr = 1'b1;
        state_next = rrts_pkg::S_OUT;
      end
      rrts_pkg::S_OUT: if (m_tready) state_next = rrts_pkg::S_IDLE;
      default: state_next = rrts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      fill <= '0;
      fin <= '0;
      for (int k = 0; k < 3; k++) begin
        cnt[k] <= '0;
        gt[k] <= '0;
      end
      do_change <= 1'b0;
    end else begin
      case (state)
        rrts_pkg::S_IDLE: if (s_tvalid) begin
          func <= s_tdata[2:0];
          idx <= s_tdata[11:3];
          t <= s_tdata[75:12];
          slot <= W'(s_tdata[11:3]);
          status <= rrts_pkg::STS_DONE;
          have_slot <= 1'b1;
          do_change <= 1'b0;
          clr_rec <= 1'b0;
        end
        rrts_pkg::S_SEARCH: if (srsp.done) begin
          slot <= srsp.slot;
          have_slot <= srsp.found;
          status <= srsp.found ? rrts_pkg::STS_DONE : rrts_pkg::STS_NONE;
          do_change <= srsp.found;
          clr_rec <= (func == rrts_pkg::FN_SUBMIT);
          new_st <= (func == rrts_pkg::FN_SUBMIT) ?
                    rrts_pkg::ST_RUNNABLE : rrts_pkg::ST_RUNNING;
          if (srsp.found && func == rrts_pkg::FN_ACQUIRE)
            ptr <= (srsp.slot == W'(rrts_pkg::TASK_SLOTS-1)) ? '0 : srsp.slot + 1'b1;
        end
        rrts_pkg::S_WAIT: begin
          // never-claimed slots read as zero
          rec <= (clr_rec || {1'b0, slot} >= fill) ? '0 : rd;
          old_st <= clr_rec ? rrts_pkg::ST_FREE : rd_st;
          if (func != rrts_pkg::FN_SUBMIT && func != rrts_pkg::FN_ACQUIRE) begin
            do_change <= 1'b1;
            case (func)
              rrts_pkg::FN_YIELD:   new_st <= rrts_pkg::ST_RUNNABLE;
              rrts_pkg::FN_EXIT:    new_st <= rrts_pkg::ST_FREE;
              rrts_pkg::FN_BLOCK:   new_st <= rrts_pkg::ST_BLOCKED;
              rrts_pkg::FN_UNBLOCK: new_st <= rrts_pkg::ST_RUNNABLE;
              default: begin
                do_change <= 1'b0;
                status <= rrts_pkg::STS_BAD;
              end
            endcase
            if (func == rrts_pkg::FN_UNBLOCK ? rd_st != rrts_pkg::ST_BLOCKED
                : (func >= rrts_pkg::FN_YIELD && func <= rrts_pkg::FN_BLOCK &&
                   rd_st != rrts_pkg::ST_RUNNING)) begin
              do_change <= 1'b0;
              status <= rrts_pkg::STS_BAD;
            end
          end
        end
        rrts_pkg::S_UPD: begin
          rec <= rec_wr;
          if (acc_en) begin
            gt[ok] <= glob_sum;
            if (cnt[ok] != 10'd0) cnt[ok] <= cnt[ok] - 1'b1;
          end
          if (new_st != rrts_pkg::ST_FREE) begin
            if (acc_en && nk == ok) cnt[nk] <= cnt[nk];
            else if (cnt[nk] != 10'(rrts_pkg::CNT_MAX)) cnt[nk] <= cnt[nk] + 1'b1;
          end
          if (func == rrts_pkg::FN_EXIT) fin <= fin + 1'b1;
          // advance the fill mark when the first unclaimed slot is taken
          if (func == rrts_pkg::FN_SUBMIT && {1'b0, slot} == fill) fill <= fill + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = (state == rrts_pkg::S_OUT);
  assign m_tdata = {7'd0,
                    have_slot ? rec[255:192] : 64'd0,
                    have_slot ? rec[191:128] : 64'd0,
                    have_slot ? rec[127:64]  : 64'd0,
                    gt[2], gt[1], gt[0], fin, cnt[2], cnt[1], cnt[0],
                    have_slot ? 9'(slot) : (status == rrts_pkg::STS_BAD ? idx : 9'd0),
                    status};

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_upd_single: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> !ram_we) else $error("double record write");
endmodule

### src/rrts_ram.sv
// Generic single-port RAM with registered read.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### src/rrts_search.sv
// Slot state RAM and the iterative slot search, one slot per cycle.
module rrts_search (
  input  logic                             clk,
  input  logic                             rst,
  input  rrts_pkg::srch_req_t              req,
  input  logic [rrts_pkg::SLOT_W-1:0]      ptr,
  input  logic [rrts_pkg::SLOT_W:0]        fill,
  input  logic                             wr,
  input  logic [rrts_pkg::SLOT_W-1:0]      wr_slot,
  input  logic [1:0]                       wr_st,
  input  logic [rrts_pkg::SLOT_W-1:0]      rd_slot,
  output logic [1:0]                       rd_st,
  output rrts_pkg::srch_rsp_t              rsp
);
  localparam int N = rrts_pkg::TASK_SLOTS;
  localparam int W = rrts_pkg::SLOT_W;

  logic [W-1:0] cur, cur_d, addr;
  logic [W:0]   left;
  logic [1:0]   want, rdata, cur_st;
  logic         busy, chk;

  assign addr = wr ? wr_slot : (busy ? cur : rd_slot);

  rrts_ram #(.WIDTH(2), .DEPTH(N)) u_st (
    .clk, .we(wr), .addr, .wdata(wr_st), .rdata
  );

  // slots at or above the fill mark were never claimed and read as free
  assign cur_st = ({1'b0, cur_d} >= fill) ? rrts_pkg::ST_FREE : rdata;
  assign rd_st = ({1'b0, rd_slot} >= fill) ? rrts_pkg::ST_FREE : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk <= 1'b0;
      rsp <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        chk <= 1'b0;
        want <= req.want;
        cur <= req.rotate ? ptr : '0;
        left <= (W+1)'(N);
      end else if (busy) begin
        // issue one slot per cycle, check its state from the registered read
        if (chk && cur_st == want) begin
          busy <= 1'b0;
          chk <= 1'b0;
          rsp <= '{done: 1'b1, found: 1'b1, slot: cur_d};
        end else if (left == '0) begin
          busy <= 1'b0;
          chk <= 1'b0;
          rsp <= '{done: 1'b1, found: 1'b0, slot: '0};
        end else begin
          cur_d <= cur;
          cur <= (cur == W'(N-1)) ? '0 : cur + 1'b1;
          left <= left - 1'b1;
          chk <= 1'b1;
        end
      end
    end
  end
endmodule

### src/rrts_acct.sv
// Shared 64-bit adders for time accounting of one state change.
module rrts_acct (
  input  logic        clk,
  input  logic [63:0] stamp,
  input  logic [63:0] t,
  input  logic [63:0] slot_tot,
  input  logic [63:0] glob_tot,
  output logic [63:0] slot_sum,
  output logic [63:0] glob_sum
);
  logic [63:0] d;
  assign d = t - stamp;
  always_ff @(posedge clk) begin
    slot_sum <= slot_tot + d;
    glob_sum <= glob_tot + d;
  end
endmodule
